FILE: hdl/mos6502_effective_address_unit_core_defines.svh
// Assertion macros used by the port checker of the 6502 effective address unit.
`ifndef MOS6502_EFFECTIVE_ADDRESS_UNIT_CORE_DEFINES_SVH
`define MOS6502_EFFECTIVE_ADDRESS_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define M6502_EA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define M6502_EA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/m6502_ea_pkg.sv
// Package with the item types and codes of the 6502 effective address unit.
`default_nettype none

package m6502_ea_pkg;

	// Command codes of an input item.
	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// Addressing mode codes.
	localparam logic [3:0] MODE_IMM = 4'd0;
	localparam logic [3:0] MODE_IMP = 4'd1;
	localparam logic [3:0] MODE_ZP  = 4'd2;
	localparam logic [3:0] MODE_ZPX = 4'd3;
	localparam logic [3:0] MODE_ZPY = 4'd4;
	localparam logic [3:0] MODE_REL = 4'd5;
	localparam logic [3:0] MODE_ABS = 4'd6;
	localparam logic [3:0] MODE_ABX = 4'd7;
	localparam logic [3:0] MODE_ABY = 4'd8;
	localparam logic [3:0] MODE_IND = 4'd9;
	localparam logic [3:0] MODE_IZX = 4'd10;
	localparam logic [3:0] MODE_IZY = 4'd11;

	// Result kind codes.
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Operand fetch step codes.
	localparam logic [1:0] STEP_FIRST  = 2'd0;
	localparam logic [1:0] STEP_SECOND = 2'd1;
	localparam logic [1:0] STEP_THIRD  = 2'd2;
	localparam logic [1:0] STEP_FOURTH = 2'd3;

	// One input item.
	typedef struct packed {
		logic        command;
		logic [3:0]  mode;
		logic [15:0] start_pc;
		logic [7:0]  x_value;
		logic [7:0]  y_value;
		logic [7:0]  acc_value;
		logic [7:0]  read_data;
	} cmd_item_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] read_address;
		logic [15:0] effective_address;
		logic [15:0] branch_offset;
		logic [7:0]  implied_operand;
		logic [15:0] next_pc;
		logic        page_crossed;
	} rsp_item_t;

endpackage

`default_nettype wire

FILE: hdl/m6502_ea_cmd_if.sv
// Valid/ready channel that carries input items into the address unit.
`default_nettype none

interface m6502_ea_cmd_if;
	logic                    valid;
	logic                    ready;
	m6502_ea_pkg::cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/m6502_ea_rsp_if.sv
// Valid/ready channel that carries result items out of the address unit.
`default_nettype none

interface m6502_ea_rsp_if;
	logic                    valid;
	logic                    ready;
	m6502_ea_pkg::rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/mos6502_effective_address_unit_core.sv
// Top level of the 6502 effective address unit.
// The unit takes one item per clock cycle unless the result register stalls, and returns
// exactly one result item for each via the input and result registers. A begin
// item either finishes at once (immediate, implied and unused modes) or opens a decode
// that asks for operand and pointer bytes as read requests; each data item answers the
// outstanding request. The rate is set by the decode state, which is updated once per
// item between the input register and the result register. A stalled result register
// holds one result while the input register holds the next item.
`default_nettype none

module mos6502_effective_address_unit_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	m6502_ea_cmd_if.sink      cmd,
	m6502_ea_rsp_if.source    rsp
);

	// Input register.
	m6502_ea_pkg::cmd_item_t item_s1;
	logic                    valid_s1;

	// Result register.
	m6502_ea_pkg::rsp_item_t rsp_q;
	logic                    rsp_valid_q;

	// Decode state.
	logic        busy_q;
	logic [3:0]  mode_q;
	logic [15:0] pc_q;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [1:0]  step_q;
	logic [7:0]  low_q;
	logic [15:0] ptr_q;

	// Next decode state and the result of the item in the input register.
	logic        busy_d;
	logic [3:0]  mode_d;
	logic [15:0] pc_d;
	logic [7:0]  x_d;
	logic [7:0]  y_d;
	logic [1:0]  step_d;
	logic [7:0]  low_d;
	logic [15:0] ptr_d;
	m6502_ea_pkg::rsp_item_t res;

	logic        advance;
	logic [15:0] pc1;
	logic [15:0] pc2;
	logic [15:0] base;
	logic [15:0] fin;
	logic [7:0]  idx;
	logic [7:0]  byte_in;

	// The item moves on when the result register is empty or being emptied.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign byte_in = item_s1.read_data;
	assign pc1     = pc_q + 16'd1;
	assign pc2     = pc_q + 16'd2;
	assign base    = {byte_in, low_q};

	// Index register that the held mode adds to its base.
	always_comb begin
		case (mode_q)
			m6502_ea_pkg::MODE_ZPX, m6502_ea_pkg::MODE_ABX, m6502_ea_pkg::MODE_IZX: begin
				idx = x_q;
			end
			m6502_ea_pkg::MODE_ZPY, m6502_ea_pkg::MODE_ABY, m6502_ea_pkg::MODE_IZY: begin
				idx = y_q;
			end
			default: begin
				idx = 8'h00;
			end
		endcase
	end

	assign fin = base + {8'h00, idx};

	// Decode step: one result and one state update per item.
	always_comb begin
		busy_d = busy_q;
		mode_d = mode_q;
		pc_d   = pc_q;
		x_d    = x_q;
		y_d    = y_q;
		step_d = step_q;
		low_d  = low_q;
		ptr_d  = ptr_q;
		res    = '0;

		if (item_s1.command == m6502_ea_pkg::CMD_DATA) begin
			if (!busy_q) begin
				res.result_kind = m6502_ea_pkg::KIND_ERROR;
			end else begin
				case (mode_q)
					m6502_ea_pkg::MODE_ZP, m6502_ea_pkg::MODE_ZPX,
					m6502_ea_pkg::MODE_ZPY: begin
						res.result_kind       = m6502_ea_pkg::KIND_DONE;
						res.effective_address = {8'h00, byte_in + idx};
						res.next_pc           = pc1;
						busy_d                = 1'b0;
					end
					m6502_ea_pkg::MODE_REL: begin
						res.result_kind   = m6502_ea_pkg::KIND_DONE;
						res.branch_offset = {{8{byte_in[7]}}, byte_in};
						res.next_pc       = pc1;
						busy_d            = 1'b0;
					end
					m6502_ea_pkg::MODE_ABS, m6502_ea_pkg::MODE_ABX,
					m6502_ea_pkg::MODE_ABY: begin
						if (step_q == m6502_ea_pkg::STEP_FIRST) begin
							low_d            = byte_in;
							step_d           = m6502_ea_pkg::STEP_SECOND;
							res.result_kind  = m6502_ea_pkg::KIND_READ;
							res.read_address = pc1;
						end else begin
							res.result_kind       = m6502_ea_pkg::KIND_DONE;
							res.effective_address = fin;
							res.next_pc           = pc2;
							res.page_crossed      = (base[15:8] != fin[15:8]);
							busy_d                = 1'b0;
						end
					end
					m6502_ea_pkg::MODE_IND: begin
						case (step_q)
							m6502_ea_pkg::STEP_FIRST: begin
								low_d            = byte_in;
								step_d           = m6502_ea_pkg::STEP_SECOND;
								res.result_kind  = m6502_ea_pkg::KIND_READ;
								res.read_address = pc1;
							end
							m6502_ea_pkg::STEP_SECOND: begin
								ptr_d            = base;
								step_d           = m6502_ea_pkg::STEP_THIRD;
								res.result_kind  = m6502_ea_pkg::KIND_READ;
								res.read_address = base;
							end
							m6502_ea_pkg::STEP_THIRD: begin
								low_d           = byte_in;
								step_d          = m6502_ea_pkg::STEP_FOURTH;
								res.result_kind = m6502_ea_pkg::KIND_READ;
								// The pointer's high byte wraps within its page.
								if (ptr_q[7:0] == 8'hFF) begin
									res.read_address = {ptr_q[15:8], 8'h00};
								end else begin
									res.read_address = ptr_q + 16'd1;
								end
							end
							default: begin
								res.result_kind       = m6502_ea_pkg::KIND_DONE;
								res.effective_address = base;
								res.next_pc           = pc2;
								busy_d                = 1'b0;
							end
						endcase
					end
					m6502_ea_pkg::MODE_IZX, m6502_ea_pkg::MODE_IZY: begin
						case (step_q)
							m6502_ea_pkg::STEP_FIRST: begin
								// Only X indexes the zero-page pointer.
								if (mode_q == m6502_ea_pkg::MODE_IZX) begin
									ptr_d = {8'h00, byte_in + x_q};
								end else begin
									ptr_d = {8'h00, byte_in};
								end
								step_d           = m6502_ea_pkg::STEP_SECOND;
								res.result_kind  = m6502_ea_pkg::KIND_READ;
								res.read_address = ptr_d;
							end
							m6502_ea_pkg::STEP_SECOND: begin
								low_d            = byte_in;
								step_d           = m6502_ea_pkg::STEP_THIRD;
								res.result_kind  = m6502_ea_pkg::KIND_READ;
								res.read_address = {8'h00, ptr_q[7:0] + 8'd1};
							end
							default: begin
								res.result_kind = m6502_ea_pkg::KIND_DONE;
								res.next_pc     = pc1;
								busy_d          = 1'b0;
								if (mode_q == m6502_ea_pkg::MODE_IZX) begin
									res.effective_address = base;
								end else begin
									res.effective_address = fin;
									res.page_crossed      = (base[15:8] != fin[15:8]);
								end
							end
						endcase
					end
					default: begin
						res.result_kind = m6502_ea_pkg::KIND_ERROR;
						busy_d          = 1'b0;
					end
				endcase
			end
		end else if (busy_q) begin
			res.result_kind = m6502_ea_pkg::KIND_ERROR;
		end else if (item_s1.mode == m6502_ea_pkg::MODE_IMM) begin
			res.result_kind       = m6502_ea_pkg::KIND_DONE;
			res.effective_address = item_s1.start_pc;
			res.next_pc           = item_s1.start_pc + 16'd1;
		end else if (item_s1.mode == m6502_ea_pkg::MODE_IMP) begin
			res.result_kind     = m6502_ea_pkg::KIND_DONE;
			res.implied_operand = item_s1.acc_value;
			res.next_pc         = item_s1.start_pc;
		end else if (item_s1.mode > m6502_ea_pkg::MODE_IZY) begin
			res.result_kind = m6502_ea_pkg::KIND_DONE;
			res.next_pc     = item_s1.start_pc;
		end else begin
			// Open a decode and ask for the first operand byte.
			busy_d           = 1'b1;
			mode_d           = item_s1.mode;
			pc_d             = item_s1.start_pc;
			x_d              = item_s1.x_value;
			y_d              = item_s1.y_value;
			step_d           = m6502_ea_pkg::STEP_FIRST;
			res.result_kind  = m6502_ea_pkg::KIND_READ;
			res.read_address = item_s1.start_pc;
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	// Decode control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= m6502_ea_pkg::MODE_IMM;
			step_q <= m6502_ea_pkg::STEP_FIRST;
		end else if (advance) begin
			busy_q <= busy_d;
			mode_q <= mode_d;
			step_q <= step_d;
		end
	end

	// Decode data state.
	always_ff @(posedge clk) begin
		if (advance) begin
			pc_q  <= pc_d;
			x_q   <= x_d;
			y_q   <= y_d;
			low_q <= low_d;
			ptr_q <= ptr_d;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= res;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/m6502_ea_checker.sv
// Port checker of the 6502 effective address unit and its bind to the top level.
`default_nettype none
`include "mos6502_effective_address_unit_core_defines.svh"

module m6502_ea_checker (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    rsp_valid,
	input wire logic                    rsp_ready,
	input wire m6502_ea_pkg::rsp_item_t rsp_data
);

	// A stalled result stays offered and unchanged.
	`M6502_EA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

	// An error result carries nothing but its kind.
	`M6502_EA_ASSERT_NOW(a_error_clean, rsp_valid && (rsp_data.result_kind == m6502_ea_pkg::KIND_ERROR), (rsp_data.read_address == 16'h0000) && (rsp_data.effective_address == 16'h0000) && (rsp_data.branch_offset == 16'h0000) && (rsp_data.implied_operand == 8'h00) && (rsp_data.next_pc == 16'h0000) && !rsp_data.page_crossed, "error result has nonzero fields")

	// A read request carries only its address.
	`M6502_EA_ASSERT_NOW(a_read_clean, rsp_valid && (rsp_data.result_kind == m6502_ea_pkg::KIND_READ), (rsp_data.effective_address == 16'h0000) && (rsp_data.next_pc == 16'h0000) && (rsp_data.branch_offset == 16'h0000) && !rsp_data.page_crossed, "read request has done fields set")

	// A finished branch offset is a sign-extended byte.
	`M6502_EA_ASSERT_NOW(a_offset_sext, rsp_valid && (rsp_data.result_kind == m6502_ea_pkg::KIND_DONE), ((rsp_data.branch_offset[15:8] == 8'h00) && !rsp_data.branch_offset[7]) || ((rsp_data.branch_offset[15:8] == 8'hFF) && rsp_data.branch_offset[7]), "branch offset is not sign-extended")

endmodule

bind mos6502_effective_address_unit_core m6502_ea_checker u_m6502_ea_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
